@@ hw/rtl/pure_pursuit_steering_top_macros.svh @@
// Assertion macros for the pure pursuit steering block.
// Used by pure_pursuit_steering_top; expects clk and rst_n in scope.
`ifndef PURE_PURSUIT_STEERING_TOP_MACROS_SVH
`define PURE_PURSUIT_STEERING_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pure pursuit steering check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pure pursuit steering check failed");

`endif

@@ hw/rtl/pps_pkg.sv @@
// Shared widths, register codes, reset values and types for the pure pursuit
// steering block. No dependencies.
package pps_pkg;

  // Field widths.
  localparam int DIST_W     = 32;
  localparam int HEAD_W     = 16;
  localparam int ELAPSED_W  = 20;
  localparam int RADIUS_W   = 20;
  localparam int GAIN_W     = 16;
  localparam int RATE_W     = 24;
  localparam int STEER_W    = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TURN_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEERING_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEER_RATE  = 2'd2;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = 20'd1000;
  localparam logic [GAIN_W-1:0]   GAIN_RST   = 16'd256;
  localparam logic [RATE_W-1:0]   RATE_RST   = 24'd65536;

  // Rate step: product of rate and elapsed time, divided by one million.
  localparam int STEP_W   = 17;
  localparam int PROD_W   = RATE_W + ELAPSED_W;
  localparam int STEP_Q_W = 25;
  localparam logic [ELAPSED_W-1:0] US_PER_S = 20'd1000000;
  localparam logic [STEP_W-1:0]    STEP_MAX = 17'd65536;

  // One in Q1.15, as an unsigned magnitude.
  localparam logic [STEP_W-1:0] ONE_Q15 = 17'd32768;

  // Status of the rate step unit as seen by the sequencer.
  typedef struct packed {
    logic              done;
    logic [STEP_W-1:0] step;
  } pps_step_stat_t;

endpackage

@@ hw/rtl/pps_step.sv @@
// Rate step unit: max_steer_rate * elapsed_us / 1000000, clamped to one full
// swing. Bit-serial multiply, then restoring division by the constant. Uses pps_pkg.
module pps_step (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pps_pkg::RATE_W-1:0]   rate,
  input  logic [pps_pkg::ELAPSED_W-1:0] elapsed,
  output pps_pkg::pps_step_stat_t      stat
);
  import pps_pkg::*;

  localparam logic [1:0] SU_IDLE = 2'd0;
  localparam logic [1:0] SU_MUL  = 2'd1;
  localparam logic [1:0] SU_DIV  = 2'd2;

  localparam logic [4:0] MUL_LAST = 5'(ELAPSED_W - 1);
  localparam logic [4:0] DIV_LAST = 5'(STEP_Q_W - 1);

  logic [1:0]           state_r, state_nxt;
  logic [4:0]           cnt_r, cnt_nxt;
  logic                 done_r;
  logic [ELAPSED_W-1:0] e_sh_r;
  logic [PROD_W-1:0]    mcand_r;
  logic [PROD_W-1:0]    acc_r;
  logic [PROD_W-1:0]    dv_r;
  logic [STEP_Q_W-1:0]  q_r;
  logic                 ge;

  // Divisor shifted to the top quotient position compares against the remainder.
  assign ge = (dv_r <= acc_r);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      SU_IDLE: begin
        if (start) begin
          state_nxt = SU_MUL;
          cnt_nxt   = '0;
        end
      end
      SU_MUL: begin
        if (cnt_r == MUL_LAST) begin
          state_nxt = SU_DIV;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      SU_DIV: begin
        if (cnt_r == DIV_LAST) begin
          state_nxt = SU_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      default: begin
        state_nxt = SU_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SU_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (start) begin
        done_r <= 1'b0;
      end else if (state_r == SU_DIV && cnt_r == DIV_LAST) begin
        done_r <= 1'b1;
      end
    end
  end

  // Datapath: shift-add multiply, then one quotient bit per cycle.
  always_ff @(posedge clk) begin
    case (state_r)
      SU_IDLE: begin
        if (start) begin
          e_sh_r  <= elapsed;
          mcand_r <= {{ELAPSED_W{1'b0}}, rate};
          acc_r   <= '0;
        end
      end
      SU_MUL: begin
        if (e_sh_r[0]) begin
          acc_r <= acc_r + mcand_r;
        end
        mcand_r <= {mcand_r[PROD_W-2:0], 1'b0};
        e_sh_r  <= {1'b0, e_sh_r[ELAPSED_W-1:1]};
        if (cnt_r == MUL_LAST) begin
          dv_r <= {US_PER_S, {(PROD_W - ELAPSED_W){1'b0}}};
        end
      end
      SU_DIV: begin
        if (ge) begin
          acc_r <= acc_r - dv_r;
        end
        dv_r <= {1'b0, dv_r[PROD_W-1:1]};
        q_r  <= {q_r[STEP_Q_W-2:0], ge};
      end
      default: begin
      end
    endcase
  end

  // Clamp to one full swing of the steering range.
  assign stat.done = done_r;
  assign stat.step = (q_r > {{(STEP_Q_W - STEP_W){1'b0}}, STEP_MAX}) ? STEP_MAX
                                                                    : q_r[STEP_W-1:0];

endmodule

@@ hw/rtl/pure_pursuit_steering_top.sv @@
// Pure pursuit steering controller, top level. Depends on pps_pkg, pps_step
// and the assertion macros in pure_pursuit_steering_top_macros.svh.
//
// An item with a nonzero offset passes through the bit-serial datapath in order:
// the heading products, a combine step, the radius product, the quotient loop
// of the curvature ratio and the gain product, then a finish step that waits
// for the output to be free and for the rate step unit, which works alongside.
// The next item is taken once the sequencer is back in idle. An item with zero
// offset holds the last steering and goes straight to the finish step. A new
// item is accepted while a finished result still waits on the output.
// Configuration writes are taken every cycle.
`include "pure_pursuit_steering_top_macros.svh"

module pure_pursuit_steering_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input items
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [pps_pkg::DIST_W-1:0]    in_target_dx,
  input  logic signed [pps_pkg::DIST_W-1:0]    in_target_dy,
  input  logic signed [pps_pkg::HEAD_W-1:0]    in_heading_x,
  input  logic signed [pps_pkg::HEAD_W-1:0]    in_heading_y,
  input  logic        [pps_pkg::ELAPSED_W-1:0] in_elapsed_us,
  // Result items
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [pps_pkg::STEER_W-1:0]   out_steer_cmd,
  output logic                           out_held,
  // Configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pps_pkg::*;

  // Widths of the internal datapath.
  localparam int PROD_HW  = DIST_W + HEAD_W;      // heading products
  localparam int CROSS_W  = PROD_HW + 1;
  localparam int SQ_W     = 2 * DIST_W;           // squared distance
  localparam int RAD2_W   = RADIUS_W + 1;         // 2 * radius
  localparam int NUM_W    = PROD_HW + RAD2_W;     // |cross| * 2 * radius
  localparam int Q_W      = STEER_W;              // saturation bit plus 15 bits
  localparam int DV_W     = SQ_W + Q_W - 1;
  localparam int GACC_W   = Q_W + GAIN_W;
  localparam int RES_W    = STEP_W + 2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HMUL = 3'd1;
  localparam logic [2:0] S_CMB  = 3'd2;
  localparam logic [2:0] S_NUM  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_GAIN = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  localparam logic [4:0] HMUL_LAST = 5'(HEAD_W - 1);
  localparam logic [4:0] NUM_LAST  = 5'(RAD2_W - 1);
  localparam logic [4:0] DIV_LAST  = 5'(Q_W - 1);
  localparam logic [4:0] GAIN_LAST = 5'(GAIN_W - 1);

  // Control state.
  logic [2:0]                 state_r, state_nxt;
  logic [4:0]                 cnt_r, cnt_nxt;
  logic [RADIUS_W-1:0]        radius_r;
  logic [GAIN_W-1:0]          gain_r;
  logic [RATE_W-1:0]          rate_r;
  logic signed [STEER_W-1:0]  last_steer_r;
  logic                       out_valid_r;
  logic signed [STEER_W-1:0]  out_steer_cmd_r;
  logic                       out_held_r;
  logic                       held_r;

  // Datapath registers.
  logic [HEAD_W-1:0]          hx_sh_r, hy_sh_r;
  logic [PROD_HW-1:0]         dx_m_r, dy_m_r;
  logic [PROD_HW-1:0]         p_hxdy_r, p_hydx_r, p_hxdx_r, p_hydy_r;
  logic [SQ_W-1:0]            ax_r, ay_r, sqx_r, sqy_r;
  logic [DIST_W-1:0]          bx_r, by_r;
  logic                       cross_neg_r, dot_neg_r;
  logic [RAD2_W-1:0]          r2_sh_r;
  logic [NUM_W-1:0]           nmc_r, num_r;
  logic [DV_W-1:0]            dv_r;
  logic [Q_W-1:0]             q_r;
  logic [GAIN_W-1:0]          g_sh_r;
  logic [GACC_W-1:0]          gm_r, gacc_r;

  // Combinational helpers.
  logic                       in_acc, zero_dist, step_start, out_free, fin_go;
  logic [DIST_W-1:0]          dx_u, dy_u, dx_abs, dy_abs;
  logic [RADIUS_W-1:0]        radius_eff;
  logic                       hmul_neg;
  logic [CROSS_W-1:0]         cross_w, cross_abs, dot_w;
  logic                       ge;
  logic [Q_W-1:0]             q_fin, mag;
  logic [GACC_W-GAIN_W+8-1:0] gmag;
  logic [STEP_W-1:0]          magc;
  logic signed [RES_W-1:0]    pos_w, desired, last_ext, step_ext, lo, hi, lim;
  logic signed [STEER_W-1:0]  new_steer;
  pps_step_stat_t             step_stat;

  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign zero_dist  = (in_target_dx == '0) && (in_target_dy == '0);
  assign step_start = in_acc && !zero_dist;
  assign out_free   = !out_valid_r || out_ready;
  assign fin_go     = (state_r == S_FIN) && out_free && (held_r || step_stat.done);

  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_steer_cmd = out_steer_cmd_r;
  assign out_held      = out_held_r;

  // Magnitudes of the offset and the effective radius.
  assign dx_u       = in_target_dx;
  assign dy_u       = in_target_dy;
  assign dx_abs     = dx_u[DIST_W-1] ? (~dx_u + 1'b1) : dx_u;
  assign dy_abs     = dy_u[DIST_W-1] ? (~dy_u + 1'b1) : dy_u;
  assign radius_eff = (radius_r == '0) ? {{(RADIUS_W-1){1'b0}}, 1'b1} : radius_r;

  // The heading sign bit carries negative weight.
  assign hmul_neg = (cnt_r == HMUL_LAST);

  // Cross and dot products from the four partial products.
  assign cross_w   = {p_hxdy_r[PROD_HW-1], p_hxdy_r} - {p_hydx_r[PROD_HW-1], p_hydx_r};
  assign dot_w     = {p_hxdx_r[PROD_HW-1], p_hxdx_r} + {p_hydy_r[PROD_HW-1], p_hydy_r};
  assign cross_abs = cross_w[CROSS_W-1] ? (~cross_w + 1'b1) : cross_w;

  // Quotient step; the first bit tested is the saturation at one.
  assign ge    = (dv_r <= {{(DV_W-NUM_W){1'b0}}, num_r});
  assign q_fin = {q_r[Q_W-2:0], ge};
  assign mag   = q_fin[Q_W-1] ? ONE_Q15[Q_W-1:0] : q_fin;

  // Gain scaling, clamp, sign and the target-behind case.
  assign gmag  = gacc_r[GACC_W-1:8];
  assign magc  = (gmag > {{(GACC_W-8-STEP_W){1'b0}}, ONE_Q15}) ? ONE_Q15
                                                              : gmag[STEP_W-1:0];
  always_comb begin
    if (dot_neg_r) begin
      pos_w = signed'({2'b00, ONE_Q15});
    end else begin
      pos_w = signed'({2'b00, magc});
    end
    desired = cross_neg_r ? -pos_w : pos_w;
  end

  // Rate limit around the last steering, then saturate to the output range.
  assign last_ext = RES_W'(last_steer_r);
  assign step_ext = signed'({2'b00, step_stat.step});
  assign lo       = last_ext - step_ext;
  assign hi       = last_ext + step_ext;
  always_comb begin
    if (desired < lo) begin
      lim = lo;
    end else if (desired > hi) begin
      lim = hi;
    end else begin
      lim = desired;
    end
    if (lim > RES_W'(32767)) begin
      new_steer = 16'sh7FFF;
    end else if (lim < -RES_W'(32768)) begin
      new_steer = -16'sh8000;
    end else begin
      new_steer = lim[STEER_W-1:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = zero_dist ? S_FIN : S_HMUL;
          cnt_nxt   = '0;
        end
      end
      S_HMUL: begin
        if (cnt_r == HMUL_LAST) begin
          state_nxt = S_CMB;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_CMB: begin
        state_nxt = S_NUM;
        cnt_nxt   = '0;
      end
      S_NUM: begin
        if (cnt_r == NUM_LAST) begin
          state_nxt = S_DIV;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_DIV: begin
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_GAIN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_GAIN: begin
        if (cnt_r == GAIN_LAST) begin
          state_nxt = S_FIN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  // Control registers, configuration, last steering and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      radius_r     <= RADIUS_RST;
      gain_r       <= GAIN_RST;
      rate_r       <= RATE_RST;
      last_steer_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_TURN_RADIUS: radius_r <= cfg_data[RADIUS_W-1:0];
          REG_STEERING_GAIN:   gain_r   <= cfg_data[GAIN_W-1:0];
          REG_MAX_STEER_RATE:  rate_r   <= cfg_data[RATE_W-1:0];
          default: begin
          end
        endcase
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
        if (!held_r) begin
          last_steer_r <= new_steer;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_steer_cmd_r <= held_r ? last_steer_r : new_steer;
      out_held_r      <= held_r;
    end
  end

  // Squared distance: two shift-add multipliers that run through the product phases.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ax_r  <= {{DIST_W{1'b0}}, dx_abs};
      ay_r  <= {{DIST_W{1'b0}}, dy_abs};
      bx_r  <= dx_abs;
      by_r  <= dy_abs;
      sqx_r <= '0;
      sqy_r <= '0;
    end else if (state_r == S_HMUL || state_r == S_CMB || state_r == S_NUM) begin
      if (bx_r[0]) begin
        sqx_r <= sqx_r + ax_r;
      end
      if (by_r[0]) begin
        sqy_r <= sqy_r + ay_r;
      end
      ax_r <= {ax_r[SQ_W-2:0], 1'b0};
      ay_r <= {ay_r[SQ_W-2:0], 1'b0};
      bx_r <= {1'b0, bx_r[DIST_W-1:1]};
      by_r <= {1'b0, by_r[DIST_W-1:1]};
    end
  end

  // Main datapath, one bit of the serial operand per cycle.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          held_r   <= zero_dist;
          hx_sh_r  <= in_heading_x;
          hy_sh_r  <= in_heading_y;
          dx_m_r   <= {{HEAD_W{in_target_dx[DIST_W-1]}}, in_target_dx};
          dy_m_r   <= {{HEAD_W{in_target_dy[DIST_W-1]}}, in_target_dy};
          p_hxdy_r <= '0;
          p_hydx_r <= '0;
          p_hxdx_r <= '0;
          p_hydy_r <= '0;
          r2_sh_r  <= {radius_eff, 1'b0};
          g_sh_r   <= gain_r;
        end
      end
      S_HMUL: begin
        // Signed heading times offset; the sign bit subtracts.
        if (hx_sh_r[0]) begin
          p_hxdy_r <= hmul_neg ? (p_hxdy_r - dy_m_r) : (p_hxdy_r + dy_m_r);
          p_hxdx_r <= hmul_neg ? (p_hxdx_r - dx_m_r) : (p_hxdx_r + dx_m_r);
        end
        if (hy_sh_r[0]) begin
          p_hydx_r <= hmul_neg ? (p_hydx_r - dx_m_r) : (p_hydx_r + dx_m_r);
          p_hydy_r <= hmul_neg ? (p_hydy_r - dy_m_r) : (p_hydy_r + dy_m_r);
        end
        dx_m_r  <= {dx_m_r[PROD_HW-2:0], 1'b0};
        dy_m_r  <= {dy_m_r[PROD_HW-2:0], 1'b0};
        hx_sh_r <= {1'b0, hx_sh_r[HEAD_W-1:1]};
        hy_sh_r <= {1'b0, hy_sh_r[HEAD_W-1:1]};
      end
      S_CMB: begin
        cross_neg_r <= cross_w[CROSS_W-1];
        dot_neg_r   <= dot_w[CROSS_W-1];
        nmc_r       <= {{RAD2_W{1'b0}}, cross_abs[PROD_HW-1:0]};
        num_r       <= '0;
      end
      S_NUM: begin
        // |cross| times twice the radius.
        if (r2_sh_r[0]) begin
          num_r <= num_r + nmc_r;
        end
        nmc_r   <= {nmc_r[NUM_W-2:0], 1'b0};
        r2_sh_r <= {1'b0, r2_sh_r[RAD2_W-1:1]};
        if (cnt_r == NUM_LAST) begin
          dv_r <= {sqx_r + sqy_r, {(Q_W-1){1'b0}}};
        end
      end
      S_DIV: begin
        // Restoring division; num_r holds the remainder.
        if (ge) begin
          num_r <= num_r - dv_r[NUM_W-1:0];
        end
        dv_r <= {1'b0, dv_r[DV_W-1:1]};
        q_r  <= q_fin;
        if (cnt_r == DIV_LAST) begin
          gm_r   <= {{GAIN_W{1'b0}}, mag};
          gacc_r <= '0;
        end
      end
      S_GAIN: begin
        if (g_sh_r[0]) begin
          gacc_r <= gacc_r + gm_r;
        end
        gm_r   <= {gm_r[GACC_W-2:0], 1'b0};
        g_sh_r <= {1'b0, g_sh_r[GAIN_W-1:1]};
      end
      default: begin
      end
    endcase
  end

  // Rate step unit, started with every item that has a nonzero offset.
  pps_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (step_start),
    .rate    (rate_r),
    .elapsed (in_elapsed_us),
    .stat    (step_stat)
  );

  // The pending result always matches the kept steering.
  `PPS_ASSERT_IMPL(a_out_matches_last, out_valid_r, out_steer_cmd_r == last_steer_r)
  // An item with a nonzero offset starts both the sequencer and the step unit.
  `PPS_ASSERT_NEXT(a_start_both, step_start, state_r == S_HMUL && !step_stat.done)
  // The divisor never reaches zero while the quotient loop runs.
  `PPS_ASSERT_IMPL(a_div_nonzero, state_r == S_DIV, dv_r != '0)

endmodule
